// File: hw/rtl/dpfp_pkg.sv
// ----------------------------------------------------------------------------
// Debug packet frame parser package
// Parser state, status and command codes, framing characters, shared types and a hex decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dpfp_pkg;

	// Parser state codes.
	localparam logic [2:0] ST_WAIT_ACK    = 3'd0;
	localparam logic [2:0] ST_WAIT_DOLLAR = 3'd1;
	localparam logic [2:0] ST_PAYLOAD     = 3'd2;
	localparam logic [2:0] ST_DIGIT_HI    = 3'd3;
	localparam logic [2:0] ST_DIGIT_LO    = 3'd4;
	localparam logic [2:0] ST_FINISHED    = 3'd5;
	localparam logic [2:0] ST_ERROR       = 3'd6;
	localparam logic [2:0] ST_NACK        = 3'd7;

	// Status codes reported with every result.
	localparam logic [1:0] STATUS_BUSY     = 2'd0;
	localparam logic [1:0] STATUS_FINISHED = 2'd1;
	localparam logic [1:0] STATUS_ERROR    = 2'd2;
	localparam logic [1:0] STATUS_NACK     = 2'd3;

	// Input command codes.
	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// Framing characters.
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_HASH   = 8'h23;

	// Parser context kept between bytes.
	typedef struct packed {
		logic [2:0] state;
		logic [7:0] sum;
		logic [3:0] high_nibble;
		logic       high_bad;
	} parse_ctx_t;

	// Per-byte flags produced by the parse step.
	typedef struct packed {
		logic [1:0] status;
		logic       payload_valid;
	} step_flags_t;

	typedef struct packed {
		logic       bad;
		logic [3:0] value;
	} hex_t;

	localparam parse_ctx_t CTX_RESET = '{
		state: ST_WAIT_ACK, sum: 8'd0, high_nibble: 4'd0, high_bad: 1'b0
	};

	// Decodes one ASCII hex digit; bad is set for anything else.
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t       r;
		logic [7:0] diff;
		r    = '{bad: 1'b1, value: 4'd0};
		diff = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			diff = c - 8'h30;
			r    = '{bad: 1'b0, value: diff[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			diff = c - 8'h57;
			r    = '{bad: 1'b0, value: diff[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			diff = c - 8'h37;
			r    = '{bad: 1'b0, value: diff[3:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dpfp_parse_step.sv
// ----------------------------------------------------------------------------
// Debug packet frame parser step
// Next parser context and result flags for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dpfp_parse_step (
	input  wire dpfp_pkg::parse_ctx_t  ctx,
	input  wire                        ack_enabled,
	input  wire [7:0]                  rx_byte,
	output dpfp_pkg::parse_ctx_t       ctx_next,
	output dpfp_pkg::step_flags_t      flags
);

	dpfp_pkg::hex_t digit;
	logic [7:0]     received_sum;

	assign digit        = dpfp_pkg::hex_decode(rx_byte);
	assign received_sum = {ctx.high_nibble, digit.value};

	always_comb begin
		ctx_next            = ctx;
		flags.payload_valid = 1'b0;
		unique case (ctx.state)
			dpfp_pkg::ST_WAIT_ACK: begin
				if (ack_enabled) begin
					if (rx_byte == dpfp_pkg::CHAR_PLUS) begin
						ctx_next.state = dpfp_pkg::ST_WAIT_DOLLAR;
					end else if (rx_byte == dpfp_pkg::CHAR_MINUS) begin
						ctx_next.state = dpfp_pkg::ST_NACK;
					end
				end else if (rx_byte == dpfp_pkg::CHAR_PLUS) begin
					ctx_next.state = dpfp_pkg::ST_WAIT_DOLLAR;
				end else if (rx_byte == dpfp_pkg::CHAR_DOLLAR) begin
					ctx_next.sum   = 8'd0;
					ctx_next.state = dpfp_pkg::ST_PAYLOAD;
				end else begin
					ctx_next.state = dpfp_pkg::ST_ERROR;
				end
			end
			dpfp_pkg::ST_WAIT_DOLLAR: begin
				if (rx_byte == dpfp_pkg::CHAR_DOLLAR) begin
					ctx_next.sum   = 8'd0;
					ctx_next.state = dpfp_pkg::ST_PAYLOAD;
				end else begin
					ctx_next.state = dpfp_pkg::ST_ERROR;
				end
			end
			dpfp_pkg::ST_PAYLOAD: begin
				if (rx_byte == dpfp_pkg::CHAR_HASH) begin
					ctx_next.state = ack_enabled ? dpfp_pkg::ST_DIGIT_HI
						: dpfp_pkg::ST_FINISHED;
				end else begin
					flags.payload_valid = 1'b1;
					ctx_next.sum        = ctx.sum + rx_byte;
				end
			end
			dpfp_pkg::ST_DIGIT_HI: begin
				ctx_next.high_nibble = digit.value;
				ctx_next.high_bad    = digit.bad;
				ctx_next.state       = dpfp_pkg::ST_DIGIT_LO;
			end
			dpfp_pkg::ST_DIGIT_LO: begin
				if (digit.bad || ctx.high_bad || received_sum != ctx.sum) begin
					ctx_next.state = dpfp_pkg::ST_ERROR;
				end else begin
					ctx_next.state = dpfp_pkg::ST_FINISHED;
				end
			end
			default: begin
				// Finished, error and nack hold until a restart.
			end
		endcase
		unique case (ctx_next.state)
			dpfp_pkg::ST_FINISHED: flags.status = dpfp_pkg::STATUS_FINISHED;
			dpfp_pkg::ST_ERROR:    flags.status = dpfp_pkg::STATUS_ERROR;
			dpfp_pkg::ST_NACK:     flags.status = dpfp_pkg::STATUS_NACK;
			default:               flags.status = dpfp_pkg::STATUS_BUSY;
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/debug_packet_frame_parser_core.sv
// ----------------------------------------------------------------------------
// Debug packet frame parser core
// Parses ['+'] '$' payload '#' [hh] framing one received byte at a time.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one received byte per transfer in s_axis_tdata,
// with s_axis_tuser selecting a normal byte (0) or a parser restart (1).
// Every input transfer produces exactly one output transfer carrying the
// status after that byte, the payload flag and byte, and the byte's position
// since the last restart (saturating at 2^INDEX_WIDTH-1, shown in 16 bits).
// The single register ack_enabled is written through the cfg channel, which
// is always ready; it should only be changed while no transfer is in flight.
// The result of a byte is shown on the output in the cycle after the byte is
// accepted, from the single output register that follows the parse logic.
// Throughput is one byte per cycle while the receiver takes every result.
// When the receiver stalls, the result is held and the input accepts one
// more byte only in the cycle the held result is taken.
// Reset clears the parser to its waiting-for-ack state, the position count
// to zero, sets ack_enabled to 1 and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module debug_packet_frame_parser_core #(
	parameter int INDEX_WIDTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// Configuration write channel: bit 0 is ack_enabled.
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_data,
	// Input stream.
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [7:0]   s_axis_tdata,  // [7:0] rx_byte
	input  wire         s_axis_tuser,  // [0] cmd
	// Result stream.
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] payload_byte, [23:8] byte_index
	output logic [2:0]  m_axis_tuser   // [1:0] status, [2] payload_valid
);

	localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = {INDEX_WIDTH{1'b1}};

	logic                     ack_enabled_q;
	dpfp_pkg::parse_ctx_t     ctx_q;
	dpfp_pkg::parse_ctx_t     ctx_next;
	dpfp_pkg::step_flags_t    flags;
	logic [INDEX_WIDTH-1:0]   position_q;
	logic [INDEX_WIDTH+15:0]  position_ext;
	logic                     in_xfer;
	logic                     restart;

	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic                     payload_valid_q;
	logic [7:0]               payload_byte_q;
	logic [15:0]              byte_index_q;

	assign cfg_ready = 1'b1;

	// The output register frees up when empty or when its result is taken.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign restart       = (s_axis_tuser == dpfp_pkg::CMD_RESTART);

	// Zero-extend before taking the low 16 bits so narrow counters still fit.
	assign position_ext = {16'd0, position_q};

	dpfp_parse_step u_step (
		.ctx         (ctx_q),
		.ack_enabled (ack_enabled_q),
		.rx_byte     (s_axis_tdata),
		.ctx_next    (ctx_next),
		.flags       (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_enabled_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			ack_enabled_q <= cfg_data;
		end
	end

	// Parser context and position count advance on every input transfer; a restart clears both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q      <= dpfp_pkg::CTX_RESET;
			position_q <= '0;
		end else if (in_xfer) begin
			if (restart) begin
				ctx_q      <= dpfp_pkg::CTX_RESET;
				position_q <= '0;
			end else begin
				ctx_q <= ctx_next;
				if (position_q != INDEX_MAX) begin
					position_q <= position_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A restart reports all-zero fields; a payload byte is shown only when flagged.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			if (restart) begin
				status_q        <= dpfp_pkg::STATUS_BUSY;
				payload_valid_q <= 1'b0;
				payload_byte_q  <= 8'd0;
				byte_index_q    <= 16'd0;
			end else begin
				status_q        <= flags.status;
				payload_valid_q <= flags.payload_valid;
				payload_byte_q  <= flags.payload_valid ? s_axis_tdata : 8'd0;
				byte_index_q    <= position_ext[15:0];
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {byte_index_q, payload_byte_q};
	assign m_axis_tuser  = {payload_valid_q, status_q};

endmodule

`default_nettype wire

// File: hw/rtl/dpfp_checker.sv
// ----------------------------------------------------------------------------
// Debug packet frame parser checker
// Port-level assertions on the parser core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module dpfp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [23:0] m_axis_tdata,
	input wire [2:0]  m_axis_tuser
);

	// A stalled result stays on offer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// The input only backs off while a result waits on the output.
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a waiting result");

	// A payload byte is only flagged while the packet is still in progress.
	a_payload_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == dpfp_pkg::STATUS_BUSY)
		else $error("payload flagged with a final status");

	// Without the payload flag the payload byte reads as zero.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[7:0] == 8'd0)
		else $error("payload byte set without payload flag");

endmodule

bind debug_packet_frame_parser_core dpfp_checker u_dpfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
